// File: sv/ficc_pkg.sv
// Package: shared types, codes and helper functions for the intensity controller.
`default_nettype none

package ficc_pkg;

    // Input modes
    localparam logic [1:0] MODE_SERIAL = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_PRESS  = 2'd2;

    // Page request codes
    localparam logic [1:0] PAGE_NONE      = 2'd0;
    localparam logic [1:0] PAGE_LOAD      = 2'd1;
    localparam logic [1:0] PAGE_INTENSITY = 2'd2;

    // Characters
    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_S     = 8'h73;  // 's'
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [6:0] LEVEL_MAX  = 7'd100;
    localparam logic [1:0] MARK_COUNT = 2'd3;
    localparam int         BODY_LEN   = 4;
    localparam logic [2:0] BODY_FULL  = 3'd4;

    // Queue depth between front/back and on the result side
    localparam logic [1:0] Q_FULL = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_CLOSE
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SET,
        CMD_PAGE,
        CMD_TICK,
        CMD_PRESS
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        rx_byte;
        logic signed [7:0] enc_delta;
    } item_t;

    typedef struct packed {
        logic [6:0] level;
        logic       display_update;
        logic       report;
        logic [1:0] page_request;
    } result_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [6:0]        value;
        logic [1:0]        page;
        logic signed [7:0] delta;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] value;
    } num_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // atoi over three characters; ok when the value is within 0..100
    function automatic num_t parse_number(input logic [7:0] c1,
                                          input logic [7:0] c2,
                                          input logic [7:0] c3);
        logic [7:0] s [3];
        logic       skip;
        logic       digits_on;
        logic       neg;
        logic [9:0] acc;
        logic [7:0] c;
        num_t       r;
        s[0] = c1;
        s[1] = c2;
        s[2] = c3;
        skip = 1'b1;
        digits_on = 1'b1;
        neg = 1'b0;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            c = s[i];
            if (skip && is_ws(c)) begin
                skip = 1'b1;
            end else if (skip && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                skip = 1'b0;
                neg = (c == CH_MINUS);
            end else if (digits_on && is_digit(c)) begin
                skip = 1'b0;
                acc = 10'(acc * 10'd10) + {2'b00, c - CH_ZERO};
            end else begin
                skip = 1'b0;
                digits_on = 1'b0;
            end
        end
        r.ok = neg ? (acc == 10'd0) : (acc <= {3'b000, LEVEL_MAX});
        r.value = acc[6:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/ficc_front.sv
// Front end: deframes serial bytes and turns every input request into a command.
`default_nettype none

module ficc_front
    import ficc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire item_t item,
    output cmd_t       cmd
);

    phase_t     phase_reg, phase_next;
    logic [1:0] open_reg, open_next;
    logic [1:0] close_reg, close_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] body_reg [BODY_LEN];
    logic       body_we;
    num_t       num;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_HUNT;
            open_reg  <= '0;
            close_reg <= '0;
            pos_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < BODY_LEN; i++) begin
                body_reg[i] <= '0;
            end
        end else if (accept && body_we) begin
            body_reg[pos_reg[1:0]] <= item.rx_byte;
        end
    end

    assign num = parse_number(body_reg[1], body_reg[2], body_reg[3]);

    always_comb begin
        phase_next = phase_reg;
        open_next  = open_reg;
        close_next = close_reg;
        pos_next   = pos_reg;
        body_we    = 1'b0;
        cmd        = '0;
        cmd.kind   = CMD_NOP;
        case (item.mode)
            MODE_SERIAL: begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (item.rx_byte == CH_OPEN) begin
                            open_next = open_reg + 2'd1;
                            if (open_next == MARK_COUNT) begin
                                phase_next = PH_BODY;
                                pos_next   = '0;
                            end
                        end else begin
                            open_next = '0;
                        end
                    end
                    PH_BODY: begin
                        if (item.rx_byte == CH_CLOSE) begin
                            phase_next = PH_CLOSE;
                            close_next = 2'd1;
                        end else if (pos_reg < BODY_FULL) begin
                            body_we  = 1'b1;
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    PH_CLOSE: begin
                        phase_next = PH_HUNT;
                        open_next  = '0;
                        close_next = '0;
                        pos_next   = '0;
                        if (item.rx_byte == CH_CLOSE) begin
                            close_next = close_reg + 2'd1;
                            if (close_next == MARK_COUNT) begin
                                close_next = '0;
                                if (body_reg[0] == CH_I) begin
                                    if (num.ok) begin
                                        cmd.kind  = CMD_SET;
                                        cmd.value = num.value;
                                    end
                                end else if (body_reg[0] == CH_L) begin
                                    cmd.kind = CMD_PAGE;
                                    cmd.page = PAGE_LOAD;
                                end else if (body_reg[0] == CH_S) begin
                                    cmd.kind = CMD_PAGE;
                                    cmd.page = PAGE_INTENSITY;
                                end
                            end else begin
                                // frame still closing
                                phase_next = PH_CLOSE;
                                pos_next   = pos_reg;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                        open_next  = '0;
                        close_next = '0;
                        pos_next   = '0;
                    end
                endcase
            end
            MODE_TICK: begin
                cmd.kind  = CMD_TICK;
                cmd.delta = item.enc_delta;
            end
            MODE_PRESS: begin
                cmd.kind = CMD_PRESS;
            end
            default: begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/ficc_cmd_q.sv
// Two-entry command queue between front end and back end.
`default_nettype none

module ficc_cmd_q
    import ficc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      head
);

    cmd_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == Q_FULL);
    assign valid   = (cnt_reg != 2'd0);
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// File: sv/ficc_back.sv
// Back end: executes commands on the level and queues results.
`default_nettype none

module ficc_back
    import ficc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_take,
    input  wire logic pop,
    output logic      empty,
    output result_t   result
);

    logic [6:0]        level_reg, level_next;
    logic              pend_reg, pend_next;
    result_t           res;
    logic signed [9:0] sum;

    result_t    mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign cmd_take = cmd_valid && (cnt_reg != Q_FULL);
    assign empty    = (cnt_reg == 2'd0);
    assign result   = mem_reg[rd_reg];
    assign do_pop   = pop && !empty;

    assign sum = $signed({3'b000, level_reg}) + 10'(cmd.delta);

    always_comb begin
        level_next = level_reg;
        pend_next  = pend_reg;
        res        = '0;
        case (cmd.kind)
            CMD_SET: begin
                level_next = cmd.value;
                pend_next  = 1'b1;
            end
            CMD_PAGE: begin
                res.page_request = cmd.page;
            end
            CMD_TICK: begin
                if (cmd.delta != 8'sd0) begin
                    if (sum > $signed({3'b000, LEVEL_MAX})) begin
                        level_next = LEVEL_MAX;
                    end else if (sum < 10'sd0) begin
                        level_next = '0;
                    end else begin
                        level_next = sum[6:0];
                    end
                    res.report = 1'b1;
                    pend_next  = 1'b1;
                end
                // refresh owed display on every tick
                res.display_update = pend_next;
                pend_next          = 1'b0;
            end
            CMD_PRESS: begin
                level_next = (level_reg != 7'd0) ? 7'd0 : LEVEL_MAX;
                pend_next  = 1'b1;
                res.report = 1'b1;
            end
            default: begin
                level_next = level_reg;
            end
        endcase
        res.level = level_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            level_reg <= '0;
            pend_reg  <= 1'b1;
        end else if (cmd_take) begin
            level_reg <= level_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd_take) begin
            mem_reg[wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (cmd_take) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, cmd_take} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// File: sv/framed_intensity_command_controller_top.sv
// Top level of the framed intensity command controller.
`default_nettype none

// Keeps an intensity level of 0..100 driven by serial bytes, encoder ticks and
// centre-switch long presses, and returns exactly one result per request. Both
// sides behave as queues: a request enters on push while full is low, and the
// oldest result sits on the result port while empty is low and leaves on pop.
// Sustained rate is one request per clock cycle while pop stays high. The
// front end deframes serial bytes ("<<<" body ">>>") and parses 'i' numbers
// in the same cycle a request is accepted, pushing a command into a two-entry
// queue. The back end takes one command a cycle while the output queue has
// room, updates the level (saturating encoder add, long-press toggle, framed
// set) and writes the result into a two-entry output queue, so a stalled
// consumer backs up through the command queue before full rises. Serial bytes
// never set display_update or report; a frame body starting with 'l' or 's'
// produces a page request on the byte that completes the frame.

module framed_intensity_command_controller_top
    import ficc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    logic accept;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic head_valid;
    logic cmd_take;

    // request accepted when the command queue has room
    assign accept = push && !full;

    ficc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    ficc_cmd_q u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .full     (full),
        .pop      (cmd_take),
        .valid    (head_valid),
        .head     (head_cmd)
    );

    ficc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench: random and directed requests against a bit-accurate predictor of the controller.
`default_nettype none

module tb_top;
    import ficc_pkg::*;

    // ------------------------------------------------------------------
    // Predictor and result store.
    // Every accepted request yields exactly one result, so the store is a
    // plain in-order queue of expected results.
    // ------------------------------------------------------------------
    class level_scoreboard;
        phase_t     frame_phase;
        logic [1:0] opens;
        logic [1:0] closes;
        logic [2:0] slot;
        logic [7:0] body [4];
        logic [6:0] lvl;
        logic       refresh_owed;
        result_t    due_results [$];
        int         failures;

        function new();
            restart_frame();
            foreach (body[k])
            begin
                body[k] = '0;
            end
            lvl = '0;
            refresh_owed = 1'b1;
            failures = 0;
        endfunction

        function void restart_frame();
            frame_phase = PH_HUNT;
            opens = '0;
            closes = '0;
            slot = '0;
        endfunction

        // Advance the predicted state by one accepted request.
        function void note_request(item_t it);
            result_t    r;
            logic [7:0] c;
            int         sum;
            int         k;
            int         acc;
            logic       neg;
            r = '0;
            c = it.rx_byte;
            case (it.mode)
                MODE_SERIAL:
                begin
                    case (frame_phase)
                        PH_HUNT:
                        begin
                            if (c == CH_OPEN)
                            begin
                                opens = opens + 2'd1;
                                if (opens == MARK_COUNT)
                                begin
                                    frame_phase = PH_BODY;
                                    slot = '0;
                                end
                            end
                            else
                            begin
                                opens = '0;
                            end
                        end
                        PH_BODY:
                        begin
                            if (c == CH_CLOSE)
                            begin
                                frame_phase = PH_CLOSE;
                                closes = 2'd1;
                            end
                            else if (slot < BODY_FULL)
                            begin
                                // overflow bytes are dropped once all slots are used
                                body[slot[1:0]] = c;
                                slot = slot + 3'd1;
                            end
                        end
                        PH_CLOSE:
                        begin
                            if (c != CH_CLOSE)
                            begin
                                restart_frame();
                            end
                            else
                            begin
                                closes = closes + 2'd1;
                                if (closes == MARK_COUNT)
                                begin
                                    restart_frame();
                                    // stale slots are read as they stand
                                    if (body[0] == CH_I)
                                    begin
                                        k = 1;
                                        neg = 1'b0;
                                        acc = 0;
                                        while (k < 4 && (body[k] == CH_SPACE ||
                                               (body[k] >= CH_TAB && body[k] <= CH_CR)))
                                            k++;
                                        if (k < 4 && (body[k] == CH_PLUS || body[k] == CH_MINUS))
                                        begin
                                            neg = (body[k] == CH_MINUS);
                                            k++;
                                        end
                                        while (k < 4 && body[k] >= CH_ZERO && body[k] <= CH_NINE)
                                        begin
                                            acc = acc * 10 + int'(body[k] - CH_ZERO);
                                            k++;
                                        end
                                        if (neg)
                                            acc = -acc;
                                        if (acc >= 0 && acc <= int'(LEVEL_MAX))
                                        begin
                                            lvl = 7'(acc);
                                            refresh_owed = 1'b1;
                                        end
                                    end
                                    else if (body[0] == CH_L)
                                    begin
                                        r.page_request = PAGE_LOAD;
                                    end
                                    else if (body[0] == CH_S)
                                    begin
                                        r.page_request = PAGE_INTENSITY;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            restart_frame();
                        end
                    endcase
                end
                MODE_TICK:
                begin
                    if (it.enc_delta != '0)
                    begin
                        sum = int'(lvl) + int'($signed(it.enc_delta));
                        if (sum > int'(LEVEL_MAX))
                            sum = int'(LEVEL_MAX);
                        else if (sum < 0)
                            sum = 0;
                        lvl = 7'(sum);
                        refresh_owed = 1'b1;
                        r.report = 1'b1;
                    end
                    if (refresh_owed)
                    begin
                        r.display_update = 1'b1;
                        refresh_owed = 1'b0;
                    end
                end
                MODE_PRESS:
                begin
                    lvl = (lvl != '0) ? '0 : LEVEL_MAX;
                    refresh_owed = 1'b1;
                    r.report = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.level = lvl;
            due_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: level %0d disp %0d report %0d page %0d",
                             got.level, got.display_update, got.report, got.page_request);
                return;
            end
            want = due_results.pop_front();
            if (got.level !== want.level || got.display_update !== want.display_update ||
                got.report !== want.report || got.page_request !== want.page_request)
            begin
                failures++;
                if (failures <= 10)
                    $display("wrong result: expected level %0d disp %0d report %0d page %0d, ",
                             want.level, want.display_update, want.report, want.page_request,
                             "got level %0d disp %0d report %0d page %0d",
                             got.level, got.display_update, got.report, got.page_request);
            end
        endfunction

        function int due_count();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic    clk = 1'b0;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    framed_intensity_command_controller_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    level_scoreboard sb = new();

    // Idle odds: 0 means no idling; otherwise one chance in N per request/cycle.
    int gap_odds   = 4;
    int stall_odds = 4;
    int sent       = 0;
    int stall_left = 0;

    // Both handshakes are sampled here with pre-edge values, so the request
    // is always noted before a result in the same cycle is checked.
    always @(posedge clk)
    begin
        if (push && !full)
            sb.note_request(item);
        if (pop && !empty)
            sb.check_result(result);
    end

    // Result side: pop held high except during random stall bursts.
    initial
    begin
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 18);
            if (stall_left != 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One request, optionally preceded by an idle burst; returns once accepted.
    task automatic send(input logic [1:0] md, input logic [7:0] ch, input logic [7:0] dl);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        item <= item_t'{mode: md, rx_byte: ch, enc_delta: dl};
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send(MODE_SERIAL, s[k], 8'($urandom_range(0, 255)));
    endtask

    // any byte but the closing mark
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_CLOSE) ? CH_OPEN : c;
    endfunction

    // characters that exercise the number reader: blanks, signs, digits, junk
    function automatic logic [7:0] number_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
        if (pick == 2)
            return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        if (pick < 9)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return plain_char();
    endfunction

    function automatic logic [7:0] any_delta();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'h80;
        if (pick == 2)
            return 8'h7F;
        if (pick < 7)
            return 8'($urandom_range(0, 40) - 20);
        return 8'($urandom_range(0, 255));
    endfunction

    // A frame with random body; mostly well formed, sometimes broken at the
    // close. Encoder events are now and then slipped between its bytes.
    task automatic send_frame();
        logic [7:0] seq [$];
        logic [7:0] head;
        int         pick;
        int         tail_len;
        int         v;
        seq = '{CH_OPEN, CH_OPEN, CH_OPEN};
        pick = $urandom_range(0, 9);
        head = (pick < 5) ? CH_I : (pick == 5) ? CH_L : (pick == 6) ? CH_S : plain_char();
        tail_len = ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 6);
        // an empty body leaves the old slots in force
        if ($urandom_range(0, 15) != 0)
        begin
            seq.push_back(head);
            if (head == CH_I && $urandom_range(0, 2) == 0)
            begin
                // a value the level will take, zero padded or with a leading blank
                v = $urandom_range(0, 100);
                seq.push_back((v < 100 && $urandom_range(0, 1)) ? CH_SPACE : CH_ZERO + 8'(v / 100));
                seq.push_back(CH_ZERO + 8'((v / 10) % 10));
                seq.push_back(CH_ZERO + 8'(v % 10));
            end
            else
            begin
                repeat (tail_len)
                    seq.push_back(head == CH_I ? number_char() : plain_char());
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            repeat (3)
                seq.push_back(CH_CLOSE);
        end
        else
        begin
            seq.push_back(CH_CLOSE);
            if ($urandom_range(0, 1))
                seq.push_back(CH_CLOSE);
            seq.push_back(plain_char());
        end
        foreach (seq[k])
        begin
            if ($urandom_range(0, 15) == 0)
                send($urandom_range(0, 3) != 0 ? MODE_TICK : MODE_PRESS,
                     8'($urandom_range(0, 255)), any_delta());
            send(MODE_SERIAL, seq[k], 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int pick;
        int next_retune;
        rst_n <= 1'b0;
        push  <= 1'b0;
        item  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: refresh owed from reset, toggles both ways, saturation at
        // both ends, zero delta, then a level set and an intensity page.
        send(MODE_TICK, 8'h00, 8'h00);
        send(MODE_PRESS, 8'hFF, 8'h00);
        send(MODE_PRESS, 8'h00, 8'hFF);
        send(MODE_TICK, 8'h00, 8'h7F);
        send(MODE_TICK, 8'h00, 8'h00);
        send(MODE_TICK, 8'h00, 8'h80);
        send(MODE_TICK, 8'h00, 8'h01);
        send_text("<<<i100>>>");
        send_text("<<<s>>>");

        // Random part; idling levels change every hundred requests and stop
        // altogether for the tail of the run.
        next_retune = 0;
        while (sent < 700)
        begin
            if (sent >= next_retune)
            begin
                next_retune += 100;
                pick = $urandom_range(0, 2);
                gap_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
                pick = $urandom_range(0, 2);
                stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
            end
            if (sent >= 600)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send_frame();
            else if (pick < 13)
                send(MODE_TICK, 8'($urandom_range(0, 255)), any_delta());
            else if (pick < 15)
                send(MODE_PRESS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                send(MODE_SERIAL, $urandom_range(0, 2) == 0 ? CH_OPEN : 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
        push <= 1'b0;

        // Drain, then a few quiet cycles to catch stray results.
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("framed_intensity_command_controller_top: match");
        else
            $display("framed_intensity_command_controller_top: mismatch");
        $finish;
    end

    // Watchdog, well past the slowest legal run.
    initial
    begin
        #5000000;
        $display("framed_intensity_command_controller_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: framed_intensity_command_controller_top.f
sv/ficc_pkg.sv
sv/ficc_front.sv
sv/ficc_cmd_q.sv
sv/ficc_back.sv
sv/framed_intensity_command_controller_top.sv
tb/sv/tb_top.sv
